### hw/rtl/ffet_pkg.sv
// ffet_pkg: shared types and codes for the first-fit free extent table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ffet_pkg;
   localparam int unsigned FIELD_BITS = 32;

   typedef enum logic [1:0] {
      OP_ALLOC    = 2'd0,
      OP_FREE     = 2'd1,
      OP_COALESCE = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_NOFIT = 2'd1,
      ST_FULL  = 2'd2,
      ST_RSVD  = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]            op;
      logic [FIELD_BITS-1:0] addr;
      logic [FIELD_BITS-1:0] size;
   } req_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] granted_addr;
      logic [1:0]            status;
      logic [4:0]            extent_count;
   } rsp_type;
endpackage
`default_nettype wire

### hw/rtl/first_fit_free_extent_table.sv
// first_fit_free_extent_table: sequencer walking a single extent memory
// depends on ffet_pkg and ffet_mem
// an empty-table allocate, a full-table free, an unused op or a coalesce with fewer than
// two extents goes straight to the result; the other ops walk the extents held
// each entry is read, then evaluated or written, so the memory port sets the rate;
// one operation at a time, the next transfer is accepted in the cycle after the result
// transfer; reset clears the state, the extent count and the result valid, not the memory
`timescale 1ns / 1ps
`default_nettype none
module first_fit_free_extent_table
   import ffet_pkg::*;
#(
   parameter int unsigned MAX_EXTENTS = 16,
   parameter int unsigned ADDR_BITS   = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);
   localparam int unsigned IDX_W = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_EXTENTS + 1);
   localparam int unsigned DW    = 2 * ADDR_BITS;
   localparam logic [ADDR_BITS-1:0] AMAX = '1;

   typedef enum logic [3:0] {
      S_IDLE, S_AREAD, S_AEVAL, S_RMRD, S_RMWR,
      S_FREAD, S_FEVAL, S_INSRD, S_INSWR, S_INSFIN,
      S_CRD0, S_CRD1, S_CEVAL, S_CFIN, S_RESP
   } state_type;

   state_type            state_ff;
   logic [CNT_W-1:0]     count_ff, idx_ff, pos_ff;
   logic [ADDR_BITS-1:0] addr_ff, size_ff, gaddr_ff;
   logic [ADDR_BITS-1:0] cur_base_ff, cur_len_ff;
   logic [1:0]           status_ff;
   logic                 rsp_valid_ff;

   logic                 wr_en;
   logic [IDX_W-1:0]     wr_idx, rd_idx;
   logic [DW-1:0]        wr_data, rd_data;
   logic [ADDR_BITS-1:0] rd_base, rd_len;
   logic [CNT_W-1:0]     idx_next;
   logic                 last_entry;

   assign rd_base = rd_data[DW-1:ADDR_BITS];
   assign rd_len  = rd_data[ADDR_BITS-1:0];

   // walk position
   assign idx_next   = idx_ff + 1'b1;
   assign last_entry = (idx_next >= count_ff);

   ffet_mem #(.DEPTH(MAX_EXTENTS), .IDX_W(IDX_W), .DATA_W(DW)) u_mem (
      .clock, .wr_en, .wr_idx, .wr_data, .rd_idx, .rd_data
   );

   // merge helpers
   logic [ADDR_BITS:0]   end_sum, len_sum;
   logic                 adjacent;
   logic [ADDR_BITS-1:0] merged_len;
   assign end_sum    = {1'b0, cur_base_ff} + {1'b0, cur_len_ff};
   assign len_sum    = {1'b0, cur_len_ff} + {1'b0, rd_len};
   assign adjacent   = !end_sum[ADDR_BITS] && (end_sum[ADDR_BITS-1:0] == rd_base);
   assign merged_len = len_sum[ADDR_BITS] ? AMAX : len_sum[ADDR_BITS-1:0];

   // memory address and write control
   always_comb begin
      wr_en   = 1'b0;
      wr_idx  = idx_ff[IDX_W-1:0];
      wr_data = {cur_base_ff, cur_len_ff};
      rd_idx  = idx_ff[IDX_W-1:0];
      unique case (state_ff)
         S_AEVAL: begin
            wr_en   = (rd_len > size_ff);
            wr_data = {rd_base + size_ff, rd_len - size_ff};
         end
         // removal shift: entry read at idx moves to idx-1
         S_RMWR: begin
            wr_en   = 1'b1;
            wr_idx  = IDX_W'(idx_ff - 1'b1);
            wr_data = rd_data;
         end
         // insert shift: entry read at idx moves to idx+1
         S_INSWR: begin
            wr_en   = 1'b1;
            wr_idx  = IDX_W'(idx_next);
            wr_data = rd_data;
         end
         S_INSFIN: begin
            wr_en   = 1'b1;
            wr_data = {addr_ff, size_ff};
         end
         // compaction: flush the finished extent at pos, prefetch the next entry
         S_CEVAL: begin
            wr_en  = !adjacent;
            wr_idx = pos_ff[IDX_W-1:0];
            rd_idx = idx_next[IDX_W-1:0];
         end
         S_CFIN: begin
            wr_en  = 1'b1;
            wr_idx = pos_ff[IDX_W-1:0];
         end
         default: ;
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (rsp_valid_ff) begin
                  if (rsp_ready) rsp_valid_ff <= 1'b0;
               end else if (req_valid) begin
                  addr_ff   <= ADDR_BITS'(req_data.addr);
                  size_ff   <= ADDR_BITS'(req_data.size);
                  gaddr_ff  <= '0;
                  status_ff <= ST_OK;
                  idx_ff    <= '0;
                  pos_ff    <= '0;
                  unique case (op_type'(req_data.op))
                     OP_ALLOC: begin
                        if (count_ff == '0) begin
                           status_ff <= ST_NOFIT;
                           state_ff  <= S_RESP;
                        end else state_ff <= S_AREAD;
                     end
                     OP_FREE: begin
                        if (count_ff >= CNT_W'(MAX_EXTENTS)) begin
                           status_ff <= ST_FULL;
                           state_ff  <= S_RESP;
                        end else if (count_ff == '0) state_ff <= S_INSFIN;
                        else state_ff <= S_FREAD;
                     end
                     OP_COALESCE: state_ff <= (count_ff > CNT_W'(1)) ? S_CRD0 : S_RESP;
                     default: state_ff <= S_RESP;
                  endcase
               end
            end
            // allocate scan
            S_AREAD: state_ff <= S_AEVAL;
            S_AEVAL: begin
               if (rd_len >= size_ff) begin
                  gaddr_ff <= rd_base;
                  if (rd_len == size_ff && !last_entry) begin
                     idx_ff   <= idx_next;
                     state_ff <= S_RMRD;
                  end else begin
                     if (rd_len == size_ff) count_ff <= count_ff - 1'b1;
                     state_ff <= S_RESP;
                  end
               end else if (!last_entry) begin
                  idx_ff   <= idx_next;
                  state_ff <= S_AREAD;
               end else begin
                  status_ff <= ST_NOFIT;
                  state_ff  <= S_RESP;
               end
            end
            // shift entries down after a removal
            S_RMRD: state_ff <= S_RMWR;
            S_RMWR: begin
               if (!last_entry) begin
                  idx_ff   <= idx_next;
                  state_ff <= S_RMRD;
               end else begin
                  count_ff <= count_ff - 1'b1;
                  state_ff <= S_RESP;
               end
            end
            // free: find insertion point
            S_FREAD: state_ff <= S_FEVAL;
            S_FEVAL: begin
               if (rd_base < addr_ff) begin
                  if (!last_entry) begin
                     idx_ff   <= idx_next;
                     state_ff <= S_FREAD;
                  end else begin
                     idx_ff   <= count_ff;
                     state_ff <= S_INSFIN;
                  end
               end else begin
                  pos_ff   <= idx_ff;
                  idx_ff   <= count_ff - 1'b1;
                  state_ff <= S_INSRD;
               end
            end
            // insert shift, walking down to pos
            S_INSRD: state_ff <= S_INSWR;
            S_INSWR: begin
               if (idx_ff == pos_ff) state_ff <= S_INSFIN;
               else begin
                  idx_ff   <= idx_ff - 1'b1;
                  state_ff <= S_INSRD;
               end
            end
            S_INSFIN: begin
               count_ff <= count_ff + 1'b1;
               state_ff <= S_RESP;
            end
            // coalesce: cur accumulates the extent headed for pos
            S_CRD0: begin
               idx_ff   <= idx_next;
               state_ff <= S_CRD1;
            end
            S_CRD1: begin
               cur_base_ff <= rd_base;
               cur_len_ff  <= rd_len;
               state_ff    <= S_CEVAL;
            end
            S_CEVAL: begin
               if (adjacent) cur_len_ff <= merged_len;
               else begin
                  cur_base_ff <= rd_base;
                  cur_len_ff  <= rd_len;
                  pos_ff      <= pos_ff + 1'b1;
               end
               if (!last_entry) idx_ff <= idx_next;
               else state_ff <= S_CFIN;
            end
            S_CFIN: begin
               count_ff <= pos_ff + 1'b1;
               state_ff <= S_RESP;
            end
            S_RESP: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   always_comb begin
      rsp_data              = '0;
      rsp_data.granted_addr = FIELD_BITS'(gaddr_ff);
      rsp_data.status       = status_ff;
      rsp_data.extent_count = 5'(count_ff);
   end

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_EXTENTS)) else $error("extent count over capacity");
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req_ready) else $error("ready while result pending");
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INSFIN) |=> count_ff != '0) else $error("insert lost count");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result changed before transfer");
endmodule
`default_nettype wire

### hw/rtl/ffet_mem.sv
// ffet_mem: extent storage, one write port and one registered read port
// depends on ffet_pkg
`timescale 1ns / 1ps
`default_nettype none
module ffet_mem
   import ffet_pkg::*;
#(
   parameter int unsigned DEPTH  = 16,
   parameter int unsigned IDX_W  = 4,
   parameter int unsigned DATA_W = 64
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [IDX_W-1:0]  wr_idx,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [IDX_W-1:0]  rd_idx,
   output logic      [DATA_W-1:0] rd_data
);
   logic [DATA_W-1:0] mem [DEPTH];

   // synchronous write and read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      rd_data <= mem[rd_idx];
   end
endmodule
`default_nettype wire

### test/testbench.sv
// testbench: drives allocate, free, coalesce and unused-op requests into the extent table
// depends on ffet_pkg and first_fit_free_extent_table; checks against an inline predictor
`timescale 1ns / 1ps
`default_nettype none
module testbench;
   import ffet_pkg::*;

   localparam int DEPTH = 16;
   localparam int CYCLE_LIMIT = 900000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   first_fit_free_extent_table i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // predicted table state
   logic [31:0] tbl_base [DEPTH];
   logic [31:0] tbl_len [DEPTH];
   int          tbl_count = 0;

   req_type pending_reqs [$];
   rsp_type expected_rsps [$];
   int      mismatches = 0;
   int      sent_total = 0;
   int      checked_total = 0;
   int      cycle_count = 0;
   bit      all_queued = 1'b0;
   bit      quiet_tail = 1'b0;
   int      hold_until_drained = 0;
   int      send_gap = 0;
   int      recv_gap = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void drop_entry(input int idx);
      for (int k = idx; k + 1 < tbl_count; k++) begin
         tbl_base[k] = tbl_base[k+1];
         tbl_len[k] = tbl_len[k+1];
      end
      tbl_count--;
   endfunction

   // compute the response for one request and update the predicted table
   function automatic rsp_type predict_extent_op(input req_type r);
      rsp_type o;
      int      pos;
      logic [32:0] sum;
      o = '0;
      o.status = ST_OK;
      case (op_type'(r.op))
         OP_ALLOC: begin
            o.status = ST_NOFIT;
            for (int i = 0; i < tbl_count; i++) begin
               if (tbl_len[i] >= r.size) begin
                  o.granted_addr = tbl_base[i];
                  o.status = ST_OK;
                  if (tbl_len[i] == r.size) drop_entry(i);
                  else begin
                     tbl_len[i] = tbl_len[i] - r.size;
                     tbl_base[i] = tbl_base[i] + r.size;
                  end
                  break;
               end
            end
         end
         OP_FREE: begin
            if (tbl_count >= DEPTH) o.status = ST_FULL;
            else begin
               pos = 0;
               while (pos < tbl_count && tbl_base[pos] < r.addr) pos++;
               for (int k = tbl_count; k > pos; k--) begin
                  tbl_base[k] = tbl_base[k-1];
                  tbl_len[k] = tbl_len[k-1];
               end
               tbl_base[pos] = r.addr;
               tbl_len[pos] = r.size;
               tbl_count++;
            end
         end
         OP_COALESCE: begin
            pos = 0;
            while (pos + 1 < tbl_count) begin
               sum = {1'b0, tbl_base[pos]} + {1'b0, tbl_len[pos]};
               if (!sum[32] && sum[31:0] == tbl_base[pos+1]) begin
                  sum = {1'b0, tbl_len[pos]} + {1'b0, tbl_len[pos+1]};
                  tbl_len[pos] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                  drop_entry(pos + 1);
               end else pos++;
            end
         end
         default: ;
      endcase
      o.extent_count = 5'(tbl_count);
      return o;
   endfunction

   function automatic req_type make_req(input op_type op, input logic [31:0] a,
                                        input logic [31:0] s);
      req_type r;
      r.op = op;
      r.addr = a;
      r.size = s;
      return r;
   endfunction

   function automatic logic [31:0] rand_size();
      case ($urandom_range(0, 5))
         0: return 32'($urandom_range(0, 3));
         1: return $urandom;
         2: return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
         default: return 32'($urandom_range(1, 64));
      endcase
   endfunction

   // stimulus: directed corners, then mostly well-formed carve/return sequences
   initial begin
      logic [31:0] region;
      pending_reqs.push_back(make_req(OP_ALLOC, 32'h0, 32'h10));
      pending_reqs.push_back(make_req(OP_COALESCE, 32'h0, 32'h0));
      pending_reqs.push_back(make_req(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      pending_reqs.push_back(make_req(OP_FREE, 32'h100, 32'h40));
      pending_reqs.push_back(make_req(OP_FREE, 32'h100, 32'h0));
      pending_reqs.push_back(make_req(OP_ALLOC, 32'h0, 32'h0));
      pending_reqs.push_back(make_req(OP_ALLOC, 32'h0, 32'h0));
      pending_reqs.push_back(make_req(OP_FREE, 32'h140, 32'h20));
      pending_reqs.push_back(make_req(OP_FREE, 32'hFFFF_FFF0, 32'h20));
      pending_reqs.push_back(make_req(OP_FREE, 32'h0, 32'hFFFF_FFFF));
      pending_reqs.push_back(make_req(OP_FREE, 32'h8000_0000, 32'h8000_0000));
      pending_reqs.push_back(make_req(OP_FREE, 32'h10, 32'h10));
      pending_reqs.push_back(make_req(OP_COALESCE, 32'h0, 32'h0));
      pending_reqs.push_back(make_req(OP_ALLOC, 32'h0, 32'hFFFF_FFFF));
      pending_reqs.push_back(make_req(OP_ALLOC, 32'h0, 32'h30));
      pending_reqs.push_back(make_req(OP_ALLOC, 32'h0, 32'h25));
      pending_reqs.push_back(make_req(OP_ALLOC, 32'h0, 32'hFFFF_FFF0));
      for (int i = 0; i < 8; i++)
         pending_reqs.push_back(make_req(OP_FREE, 32'(i * 16), 32'h10));
      pending_reqs.push_back(make_req(OP_FREE, 32'h200, 32'h1));
      pending_reqs.push_back(make_req(OP_COALESCE, 32'h0, 32'h0));
      while (pending_reqs.size() < 1900) begin
         if ($urandom_range(0, 3) != 0) begin
            // well formed: fill with adjacent pieces, carve, merge, carve again
            region = $urandom & 32'hFFFF_F000;
            for (int i = 0; i < $urandom_range(2, 17); i++)
               pending_reqs.push_back(make_req(OP_FREE, region + 32'(i * 64),
                                               $urandom_range(0, 1) ? 32'd64 : rand_size()));
            for (int i = 0; i < $urandom_range(1, 6); i++)
               pending_reqs.push_back(make_req(OP_ALLOC, $urandom, rand_size()));
            pending_reqs.push_back(make_req(OP_COALESCE, $urandom, $urandom));
            for (int i = 0; i < $urandom_range(2, 20); i++)
               pending_reqs.push_back(make_req(OP_ALLOC, $urandom,
                                               32'($urandom_range(0, 200))));
         end else begin
            // noise with random fields of every op code
            for (int i = 0; i < $urandom_range(1, 8); i++)
               pending_reqs.push_back(make_req(op_type'($urandom_range(0, 3)),
                                               $urandom, rand_size()));
         end
      end
      all_queued = 1'b1;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         send_gap <= 0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) sent_total <= sent_total + 1;
         if (hold_until_drained == 0 && sent_total == 600 && req_valid) begin
            hold_until_drained <= 1;
            req_valid <= 1'b0;
         end else if (hold_until_drained == 1) begin
            req_valid <= 1'b0;
            if (expected_rsps.size() == 0) hold_until_drained <= 2;
         end else if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            req_valid <= 1'b0;
            send_gap <= $urandom_range(0, 6);
         end else if (pending_reqs.size() > 0) begin
            req_data <= pending_reqs[0];
            req_valid <= 1'b1;
            expected_rsps.push_back(predict_extent_op(pending_reqs.pop_front()));
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side stall and compare
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            checked_total <= checked_total + 1;
            if (expected_rsps.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) $display("unexpected result %p", rsp_data);
            end else begin
               if (rsp_data.granted_addr !== expected_rsps[0].granted_addr
                   || rsp_data.status !== expected_rsps[0].status
                   || rsp_data.extent_count !== expected_rsps[0].extent_count) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display("mismatch: expected addr %h status %0d count %0d, got %h %0d %0d",
                              expected_rsps[0].granted_addr, expected_rsps[0].status,
                              expected_rsps[0].extent_count, rsp_data.granted_addr,
                              rsp_data.status, rsp_data.extent_count);
               end
               void'(expected_rsps.pop_front());
            end
         end
         if (recv_gap > 0) begin
            rsp_ready <= 1'b0;
            recv_gap <= recv_gap - 1;
         end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            rsp_ready <= 1'b0;
            recv_gap <= $urandom_range(0, 6);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // reset, run control and end of test
   initial begin
      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait (all_queued);
      while (pending_reqs.size() > 300) @(posedge clock);
      quiet_tail = 1'b1;
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
      $display("ran %0d requests over %0d cycles, %0d results checked", sent_total,
               cycle_count, checked_total);
      $display("covered allocate, free, coalesce, unused op, full table and no fit");
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILURE");
         $finish;
      end
   end
endmodule
`default_nettype wire

### files.f
hw/rtl/ffet_pkg.sv
hw/rtl/ffet_mem.sv
hw/rtl/first_fit_free_extent_table.sv
test/testbench.sv
